FILE: src/sscc_pkg.sv
// shared constants, codes and helpers for the csr to csc converter
package sscc_pkg;

    localparam int DEF_MAX_NNZ    = 1024;
    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_MAX_ROWS   = 256;
    localparam int DEF_VALUE_BITS = 32;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_RD_ENT  = 2'd1;
    localparam logic [1:0] MODE_RD_PTR  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NDONE  = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    localparam logic [1:0] CFG_NUM_COLS = 2'd0;
    localparam logic [1:0] CFG_NUM_ROWS = 2'd1;

    localparam logic [8:0] RST_NUM_COLS = 9'd256;
    localparam logic [8:0] RST_NUM_ROWS = 9'd256;

    // address width of a memory of the given depth
    function automatic int addr_w(input int depth);
        addr_w = (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

FILE: src/sparse_csr_to_csc_convert.sv
// top level of the csr to csc sparse matrix converter
//
// usage
// - input channel (i_in_valid / o_in_ready) takes one word per item: a load of
//   one nonzero (mode load, row, column, value, last flag) or a read of one
//   csc entry or one column start pointer (read_index)
// - output channel (o_out_valid / i_out_ready) gives exactly one result word
//   per item: status, row, value and column start
// - config channel (i_cfg_valid / o_cfg_ready) writes num_cols (index 0) and
//   num_rows (index 1); always ready, write only while idle
// - a load, a rejected read or a read of pointer 0 shows its result in the cycle
//   after acceptance; a memory read passes the memory's registered read port and
//   the S_RD_WAIT state first; one item is in flight at a time, so the next item
//   is taken only once the result word is accepted
// - a load with last set starts the conversion, which runs on the memory
//   ports in order: clear, count, prefix, row scatter and column scatter;
//   no item is taken meanwhile
// - reset clears control state only; memories are not cleared, every entry
//   that a read can reach was written by the conversion
// - when the sink stalls, the result word holds and no new item is taken
module sparse_csr_to_csc_convert #(
    parameter int MAX_NNZ    = sscc_pkg::DEF_MAX_NNZ,
    parameter int MAX_COLS   = sscc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = sscc_pkg::DEF_MAX_ROWS,
    parameter int VALUE_BITS = sscc_pkg::DEF_VALUE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [7:0]         i_row_in,
    input  logic [7:0]         i_col_in,
    input  logic signed [31:0] i_value_in,
    input  logic               i_last_in,
    input  logic [9:0]         i_read_index,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [7:0]         o_row_out,
    output logic signed [31:0] o_value_out,
    output logic [10:0]        o_col_start,
    // register writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data
);

    import sscc_pkg::*;

    localparam int AW  = addr_w(MAX_NNZ);
    localparam int TW  = $clog2(MAX_NNZ + 1);
    localparam int RAW = addr_w(MAX_ROWS);
    localparam int CAW = addr_w(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int MRC = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int IW  = $clog2(MRC + 1);
    localparam int VB  = VALUE_BITS;
    localparam int EW  = 16 + VB;
    localparam int SW  = 8 + VB;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_WAIT, S_CLR,
        S_CNT_RD, S_CNT_CTR, S_CNT_WR,
        S_PFX_RD, S_PFX_WR,
        S_S1_RD, S_S1_CTR, S_S1_WR,
        S_S2_RD, S_S2_CTR, S_S2_WR
    } t_state;

    t_state            r_state;
    logic [TW-1:0]     r_count;
    logic              r_conv;
    logic [TW-1:0]     r_total;
    logic [CW-1:0]     r_ccols;
    logic [RW-1:0]     r_crows;
    logic [IW-1:0]     r_idx;
    logic [TW-1:0]     r_e;
    logic [EW-1:0]     r_ent;
    logic [TW-1:0]     r_racc;
    logic [TW-1:0]     r_cacc;
    logic              r_rmode;
    logic              r_ov;
    logic [1:0]        r_status;
    logic [7:0]        r_row_out;
    logic [31:0]       r_value_out;
    logic [10:0]       r_col_start;
    logic [8:0]        r_num_cols;
    logic [8:0]        r_num_rows;

    // memory ports
    logic              ld_we, tmp_we, csc_we, rc_we, cc_we;
    logic [AW-1:0]     ld_waddr, ld_raddr, tmp_waddr, tmp_raddr, csc_waddr, csc_raddr;
    logic [EW-1:0]     ld_wdata, ld_rdata, tmp_wdata, tmp_rdata;
    logic [SW-1:0]     csc_wdata, csc_rdata;
    logic [RAW-1:0]    rc_waddr, rc_raddr;
    logic [CAW-1:0]    cc_waddr, cc_raddr;
    logic [TW-1:0]     rc_wdata, rc_rdata, cc_wdata, cc_rdata;

    logic              acc;
    logic [CW-1:0]     eff_cols;
    logic [RW-1:0]     eff_rows;
    logic [TW-1:0]     base_cnt;
    logic              load_ok;
    logic [IW-1:0]     lim;
    logic              ent_ok;
    logic [63:0]       val_ext;
    logic [63:0]       rd_ext;
    logic [7:0]        ent_row, ent_col;

    assign acc         = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE) && !r_ov;
    assign o_cfg_ready = 1'b1;

    assign eff_cols = (32'(r_num_cols) < MAX_COLS) ? CW'(r_num_cols) : CW'(MAX_COLS);
    assign eff_rows = (32'(r_num_rows) < MAX_ROWS) ? RW'(r_num_rows) : RW'(MAX_ROWS);
    // a load after a finished conversion starts a new matrix
    assign base_cnt = r_conv ? '0 : r_count;
    assign load_ok  = (32'(i_col_in) < 32'(eff_cols)) && (32'(i_row_in) < 32'(eff_rows))
                      && (32'(base_cnt) < MAX_NNZ);
    assign lim      = (32'(r_crows) > 32'(r_ccols)) ? IW'(r_crows) : IW'(r_ccols);
    assign ent_row  = r_ent[EW-1 -: 8];
    assign ent_col  = r_ent[EW-9 -: 8];
    // entry still inside the matrix shape fixed at conversion start
    assign ent_ok   = (32'(ent_row) < 32'(r_crows)) && (32'(ent_col) < 32'(r_ccols));
    assign val_ext  = 64'(i_value_in);
    assign rd_ext   = 64'(signed'(csc_rdata[VB-1:0]));

    // memory port steering per state
    always_comb begin
        ld_we = 1'b0;  ld_waddr = '0; ld_wdata = '0; ld_raddr = '0;
        tmp_we = 1'b0; tmp_waddr = '0; tmp_wdata = '0; tmp_raddr = '0;
        csc_we = 1'b0; csc_waddr = '0; csc_wdata = '0; csc_raddr = '0;
        rc_we = 1'b0;  rc_waddr = '0; rc_wdata = '0; rc_raddr = '0;
        cc_we = 1'b0;  cc_waddr = '0; cc_wdata = '0; cc_raddr = '0;
        case (r_state)
            S_IDLE: begin
                ld_we     = acc && (i_mode == MODE_LOAD) && load_ok;
                ld_waddr  = AW'(base_cnt);
                ld_wdata  = {i_row_in, i_col_in, val_ext[VB-1:0]};
                csc_raddr = AW'(i_read_index);
                cc_raddr  = CAW'(i_read_index - 10'd1);
            end
            S_CLR: begin
                rc_we    = 32'(r_idx) < 32'(r_crows);
                rc_waddr = RAW'(r_idx);
                cc_we    = 32'(r_idx) < 32'(r_ccols);
                cc_waddr = CAW'(r_idx);
            end
            S_CNT_RD, S_S1_RD: begin
                ld_raddr = AW'(r_e);
            end
            S_CNT_CTR: begin
                rc_raddr = RAW'(ld_rdata[EW-1 -: 8]);
                cc_raddr = CAW'(ld_rdata[EW-9 -: 8]);
            end
            S_CNT_WR: begin
                rc_we    = ent_ok;
                rc_waddr = RAW'(ent_row);
                rc_wdata = rc_rdata + TW'(1);
                cc_we    = ent_ok;
                cc_waddr = CAW'(ent_col);
                cc_wdata = cc_rdata + TW'(1);
            end
            S_PFX_RD: begin
                rc_raddr = RAW'(r_idx);
                cc_raddr = CAW'(r_idx);
            end
            S_PFX_WR: begin
                rc_we    = 32'(r_idx) < 32'(r_crows);
                rc_waddr = RAW'(r_idx);
                rc_wdata = r_racc;
                cc_we    = 32'(r_idx) < 32'(r_ccols);
                cc_waddr = CAW'(r_idx);
                cc_wdata = r_cacc;
            end
            S_S1_CTR: begin
                rc_raddr = RAW'(ld_rdata[EW-1 -: 8]);
            end
            S_S1_WR: begin
                tmp_we    = ent_ok;
                tmp_waddr = AW'(rc_rdata);
                tmp_wdata = r_ent;
                rc_we     = ent_ok;
                rc_waddr  = RAW'(ent_row);
                rc_wdata  = rc_rdata + TW'(1);
            end
            S_S2_RD: begin
                tmp_raddr = AW'(r_e);
            end
            S_S2_CTR: begin
                cc_raddr = CAW'(tmp_rdata[EW-9 -: 8]);
            end
            S_S2_WR: begin
                csc_we    = 1'b1;
                csc_waddr = AW'(cc_rdata);
                csc_wdata = {ent_row, r_ent[VB-1:0]};
                cc_we     = 1'b1;
                cc_waddr  = CAW'(ent_col);
                cc_wdata  = cc_rdata + TW'(1);
            end
            default: begin
            end
        endcase
    end

    // load store, row sorted copy, csc result, row and column cursors
    sscc_ram #(.DW(EW), .DEPTH(MAX_NNZ)) u_ld (
        .i_clk(i_clk), .i_we(ld_we), .i_waddr(ld_waddr), .i_wdata(ld_wdata),
        .i_raddr(ld_raddr), .o_rdata(ld_rdata));
    sscc_ram #(.DW(EW), .DEPTH(MAX_NNZ)) u_tmp (
        .i_clk(i_clk), .i_we(tmp_we), .i_waddr(tmp_waddr), .i_wdata(tmp_wdata),
        .i_raddr(tmp_raddr), .o_rdata(tmp_rdata));
    sscc_ram #(.DW(SW), .DEPTH(MAX_NNZ)) u_csc (
        .i_clk(i_clk), .i_we(csc_we), .i_waddr(csc_waddr), .i_wdata(csc_wdata),
        .i_raddr(csc_raddr), .o_rdata(csc_rdata));
    sscc_ram #(.DW(TW), .DEPTH(MAX_ROWS)) u_rc (
        .i_clk(i_clk), .i_we(rc_we), .i_waddr(rc_waddr), .i_wdata(rc_wdata),
        .i_raddr(rc_raddr), .o_rdata(rc_rdata));
    sscc_ram #(.DW(TW), .DEPTH(MAX_COLS)) u_cc (
        .i_clk(i_clk), .i_we(cc_we), .i_waddr(cc_waddr), .i_wdata(cc_wdata),
        .i_raddr(cc_raddr), .o_rdata(cc_rdata));

    // sequencer, counters and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_conv     <= 1'b0;
            r_total    <= '0;
            r_ccols    <= '0;
            r_crows    <= '0;
            r_ov       <= 1'b0;
            r_num_cols <= RST_NUM_COLS;
            r_num_rows <= RST_NUM_ROWS;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_NUM_COLS) begin
                    r_num_cols <= i_cfg_data;
                end else if (i_cfg_index == CFG_NUM_ROWS) begin
                    r_num_rows <= i_cfg_data;
                end
            end
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_row_out   <= '0;
                        r_value_out <= '0;
                        r_col_start <= '0;
                        case (i_mode)
                            MODE_LOAD: begin
                                r_ov     <= 1'b1;
                                r_conv   <= 1'b0;
                                r_total  <= '0;
                                r_count  <= base_cnt + TW'(load_ok);
                                r_status <= load_ok ? ST_OK : ST_REJECT;
                                if (i_last_in) begin
                                    r_state <= S_CLR;
                                    r_crows <= eff_rows;
                                    r_ccols <= eff_cols;
                                    r_idx   <= '0;
                                end else begin
                                    r_ccols <= '0;
                                end
                            end
                            MODE_RD_ENT: begin
                                if (!r_conv) begin
                                    r_ov     <= 1'b1;
                                    r_status <= ST_NDONE;
                                end else if (32'(i_read_index) >= 32'(r_total)) begin
                                    r_ov     <= 1'b1;
                                    r_status <= ST_RANGE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_rmode  <= 1'b1;
                                    r_state  <= S_RD_WAIT;
                                end
                            end
                            MODE_RD_PTR: begin
                                if (!r_conv) begin
                                    r_ov     <= 1'b1;
                                    r_status <= ST_NDONE;
                                end else if (32'(i_read_index) > 32'(r_ccols)) begin
                                    r_ov     <= 1'b1;
                                    r_status <= ST_RANGE;
                                end else if (i_read_index != 10'd0) begin
                                    // start of column k is the end cursor of column k-1
                                    r_status <= ST_OK;
                                    r_rmode  <= 1'b0;
                                    r_state  <= S_RD_WAIT;
                                end else begin
                                    r_ov     <= 1'b1;
                                    r_status <= ST_OK;
                                end
                            end
                            default: begin
                                r_ov     <= 1'b1;
                                r_status <= ST_RANGE;
                            end
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    r_ov    <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_rmode) begin
                        r_row_out   <= csc_rdata[SW-1 -: 8];
                        r_value_out <= rd_ext[31:0];
                    end else begin
                        r_col_start <= 11'(cc_rdata);
                    end
                end
                S_CLR: begin
                    if (r_idx == lim) begin
                        r_state <= S_CNT_RD;
                        r_e     <= '0;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_CNT_RD: begin
                    if (r_e == r_count) begin
                        r_state <= S_PFX_RD;
                        r_idx   <= '0;
                        r_racc  <= '0;
                        r_cacc  <= '0;
                    end else begin
                        r_state <= S_CNT_CTR;
                    end
                end
                S_CNT_CTR: begin
                    r_ent   <= ld_rdata;
                    r_state <= S_CNT_WR;
                end
                S_CNT_WR: begin
                    r_e     <= r_e + TW'(1);
                    r_state <= S_CNT_RD;
                end
                S_PFX_RD: begin
                    if (r_idx == lim) begin
                        r_state <= S_S1_RD;
                        r_e     <= '0;
                        r_total <= r_cacc;
                    end else begin
                        r_state <= S_PFX_WR;
                    end
                end
                S_PFX_WR: begin
                    if (32'(r_idx) < 32'(r_crows)) begin
                        r_racc <= r_racc + rc_rdata;
                    end
                    if (32'(r_idx) < 32'(r_ccols)) begin
                        r_cacc <= r_cacc + cc_rdata;
                    end
                    r_idx   <= r_idx + IW'(1);
                    r_state <= S_PFX_RD;
                end
                S_S1_RD: begin
                    if (r_e == r_count) begin
                        r_state <= S_S2_RD;
                        r_e     <= '0;
                    end else begin
                        r_state <= S_S1_CTR;
                    end
                end
                S_S1_CTR: begin
                    r_ent   <= ld_rdata;
                    r_state <= S_S1_WR;
                end
                S_S1_WR: begin
                    r_e     <= r_e + TW'(1);
                    r_state <= S_S1_RD;
                end
                S_S2_RD: begin
                    if (r_e == r_total) begin
                        r_state <= S_IDLE;
                        r_conv  <= 1'b1;
                    end else begin
                        r_state <= S_S2_CTR;
                    end
                end
                S_S2_CTR: begin
                    r_ent   <= tmp_rdata;
                    r_state <= S_S2_WR;
                end
                S_S2_WR: begin
                    r_e     <= r_e + TW'(1);
                    r_state <= S_S2_RD;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_status;
    assign o_row_out   = r_row_out;
    assign o_value_out = r_value_out;
    assign o_col_start = r_col_start;

    // checks
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_NNZ)
        else $error("entry count above capacity");

    a_total_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_conv |-> (r_total <= r_count))
        else $error("converted total exceeds loaded entries");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_mode == MODE_LOAD) && i_last_in) |=> (r_state == S_CLR))
        else $error("last load did not start conversion");

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("item taken during conversion or read");

endmodule

FILE: src/sscc_ram.sv
// simple dual port memory, one write and one registered read per cycle
module sscc_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: dv/sparse_csr_to_csc_convert_checker.sv
// checker for the csr to csc converter: predicts every result word and compares it
module sparse_csr_to_csc_convert_checker
    import sscc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [7:0]         i_row_in,
    input  logic [7:0]         i_col_in,
    input  logic signed [31:0] i_value_in,
    input  logic               i_last_in,
    input  logic [9:0]         i_read_index,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_status,
    input  logic [7:0]         i_row_out,
    input  logic signed [31:0] i_value_out,
    input  logic [10:0]        i_col_start,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         row;
        logic signed [31:0] value;
        logic [10:0]        col_start;
    } t_result;

    localparam int NNZ  = DEF_MAX_NNZ;
    localparam int COLS = DEF_MAX_COLS;
    localparam int ROWS = DEF_MAX_ROWS;

    logic [8:0]         cols_reg, rows_reg;
    logic [7:0]         ld_row [NNZ];
    logic [7:0]         ld_col [NNZ];
    logic signed [31:0] ld_val [NNZ];
    logic [10:0]        col_ptr [COLS+1];
    logic [7:0]         out_row [NNZ];
    logic signed [31:0] out_val [NNZ];
    int                 n_loaded, n_total, conv_ncols;
    bit                 done;
    t_result            expected_q [$];

    assign o_pending = expected_q.size();

    function automatic int eff_cols();
        return (cols_reg < COLS) ? cols_reg : COLS;
    endfunction

    function automatic int eff_rows();
        return (rows_reg < ROWS) ? rows_reg : ROWS;
    endfunction

    // counting sort by column, stable in row then load order
    function automatic void transpose_matrix();
        int c_n, r_n, p;
        c_n = eff_cols();
        r_n = eff_rows();
        foreach (col_ptr[i]) col_ptr[i] = '0;
        for (int e = 0; e < n_loaded; e++)
            if (ld_col[e] < c_n && ld_row[e] < r_n) col_ptr[ld_col[e]+1]++;
        for (int c = 0; c < c_n; c++) col_ptr[c+1] += col_ptr[c];
        for (int r = 0; r < r_n; r++)
            for (int e = 0; e < n_loaded; e++) begin
                if (ld_row[e] != r || ld_col[e] >= c_n) continue;
                p = col_ptr[ld_col[e]];
                col_ptr[ld_col[e]]++;
                if (p < NNZ) begin
                    out_row[p] = r[7:0];
                    out_val[p] = ld_val[e];
                end
            end
        for (int c = c_n; c > 0; c--) col_ptr[c] = col_ptr[c-1];
        col_ptr[0] = '0;
        n_total = col_ptr[c_n];
        conv_ncols = c_n;
        done = 1;
    endfunction

    function automatic t_result predict_word();
        t_result r;
        r = '0;
        case (i_mode)
            MODE_LOAD: begin
                if (done) begin
                    done = 0; n_loaded = 0; n_total = 0; conv_ncols = 0;
                    foreach (col_ptr[i]) col_ptr[i] = '0;
                end
                if (i_col_in >= eff_cols() || i_row_in >= eff_rows() || n_loaded >= NNZ)
                    r.status = ST_REJECT;
                else begin
                    ld_row[n_loaded] = i_row_in;
                    ld_col[n_loaded] = i_col_in;
                    ld_val[n_loaded] = i_value_in;
                    n_loaded++;
                end
                if (i_last_in) transpose_matrix();
            end
            MODE_RD_ENT: begin
                if (!done) r.status = ST_NDONE;
                else if (i_read_index >= n_total) r.status = ST_RANGE;
                else begin
                    r.row = out_row[i_read_index];
                    r.value = out_val[i_read_index];
                end
            end
            MODE_RD_PTR: begin
                if (!done) r.status = ST_NDONE;
                else if (i_read_index > conv_ncols) r.status = ST_RANGE;
                else r.col_start = col_ptr[i_read_index];
            end
            default: r.status = ST_RANGE;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got, exp_w;
        if (!i_rst_n) begin
            cols_reg <= RST_NUM_COLS;
            rows_reg <= RST_NUM_ROWS;
            n_loaded = 0; n_total = 0; conv_ncols = 0; done = 0;
            foreach (col_ptr[i]) col_ptr[i] = '0;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_NUM_COLS) cols_reg <= i_cfg_data;
                else if (i_cfg_index == CFG_NUM_ROWS) rows_reg <= i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_status, i_row_out, i_value_out, i_col_start};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = expected_q.pop_front();
                    if (got !== exp_w) begin
                        $display("%0t: mismatch expected st=%0d row=%0d val=%0d cs=%0d",
                                 $time, exp_w.status, exp_w.row, exp_w.value, exp_w.col_start);
                        $display("%0t:          actual   st=%0d row=%0d val=%0d cs=%0d",
                                 $time, got.status, got.row, got.value, got.col_start);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) expected_q.push_back(predict_word());
        end
    end

endmodule

FILE: dv/sparse_csr_to_csc_convert_test.sv
// stimulus and verdict for the csr to csc converter testbench
module sparse_csr_to_csc_convert_test;
    import sscc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // mode code with no operation behind it
    localparam logic [1:0] MODE_BAD = 2'd3;

    logic               i_clk, i_rst_n;
    logic               i_in_valid, o_in_ready;
    logic [1:0]         i_mode;
    logic [7:0]         i_row_in, i_col_in;
    logic signed [31:0] i_value_in;
    logic               i_last_in;
    logic [9:0]         i_read_index;
    logic               o_out_valid, i_out_ready;
    logic [1:0]         o_status;
    logic [7:0]         o_row_out;
    logic signed [31:0] o_value_out;
    logic [10:0]        o_col_start;
    logic               i_cfg_valid, o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [8:0]         i_cfg_data;
    int                 fail_count, pending;

    // idle rates in percent, sink hold-off request
    int                 send_idle_pct, recv_idle_pct;
    bit                 hold_sink;
    int                 idle_cycles;

    // shadow of the row/column registers, for legal stimulus
    int                 cur_cols, cur_rows;

    sparse_csr_to_csc_convert u_top (.*);

    sparse_csr_to_csc_convert_checker u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_mode, .i_row_in,
        .i_col_in, .i_value_in, .i_last_in, .i_read_index, .i_out_valid(o_out_valid),
        .i_out_ready, .i_status(o_status), .i_row_out(o_row_out),
        .i_value_out(o_value_out), .i_col_start(o_col_start), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // sink: random stall at the set rate, or a long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 0;
        else i_out_ready <= !hold_sink && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: counts cycles without any accepted word and ends the run as failed
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 200000) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // one word: random gap first, then hold until accepted; valid stays up
    // after acceptance so the next word can follow directly
    task automatic send_word(input logic [1:0] mode, input logic [7:0] row,
                             input logic [7:0] col, input logic [31:0] val,
                             input logic last, input logic [9:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1;
        i_mode       <= mode;
        i_row_in     <= row;
        i_col_in     <= col;
        i_value_in   <= val;
        i_last_in    <= last;
        i_read_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop offering, wait for every result and for any conversion to end
    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0 || !o_in_ready) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        drain();
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        if (idx == CFG_NUM_COLS) cur_cols = int'(data); else cur_rows = int'(data);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // a mostly well-formed matrix: rows mostly nondecreasing, mostly legal columns
    task automatic load_matrix(input int n);
        int r, c_lim, r_lim;
        c_lim = (cur_cols > 256) ? 256 : cur_cols;
        r_lim = (cur_rows > 256) ? 256 : cur_rows;
        r = 0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(2) == 0 && r < r_lim - 1) r = $urandom_range(r_lim - 1, r);
            send_word(MODE_LOAD, ($urandom_range(19) == 0) ? 8'($urandom) : 8'(r),
                      ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(c_lim - 1)),
                      rand_value(), k == n - 1, 10'($urandom));
        end
    endtask

    // reads of entries and pointers, some past the ends, some with a bad mode
    task automatic read_back(input int n);
        logic [1:0] m;
        for (int k = 0; k < n; k++) begin
            m = ($urandom_range(19) == 0) ? MODE_BAD
                : (($urandom_range(1) == 0) ? MODE_RD_ENT : MODE_RD_PTR);
            send_word(m, 8'($urandom), 8'($urandom), $urandom, 1'($urandom),
                      ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(40)));
        end
    endtask

    initial begin
        int items, n_ld, n_rd;
        i_rst_n = 0; i_in_valid = 0; i_mode = '0; i_row_in = '0; i_col_in = '0;
        i_value_in = '0; i_last_in = 0; i_read_index = '0; i_cfg_valid = 0;
        i_cfg_index = '0; i_cfg_data = '0; hold_sink = 0;
        send_idle_pct = 16; recv_idle_pct = 56;
        cur_cols = 256; cur_rows = 256;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reads before conversion, extremes, rejects, bad mode
        send_word(MODE_RD_ENT, 8'd0, 8'd0, 32'd0, 1'b0, 10'd0);
        send_word(MODE_RD_PTR, 8'd0, 8'd0, 32'd0, 1'b0, 10'd0);
        send_word(MODE_BAD, 8'd0, 8'd0, 32'd0, 1'b0, 10'h3ff);
        send_word(MODE_LOAD, 8'd5, 8'd255, 32'h8000_0000, 1'b0, 10'd0);
        send_word(MODE_LOAD, 8'd0, 8'd0, 32'h7fff_ffff, 1'b0, 10'h3ff);
        send_word(MODE_LOAD, 8'd255, 8'd3, 32'hffff_ffff, 1'b0, 10'd0);
        send_word(MODE_LOAD, 8'd2, 8'd0, 32'h1, 1'b0, 10'd0);   // row out of order
        send_word(MODE_LOAD, 8'd2, 8'd255, 32'h0, 1'b0, 10'd0);
        send_word(MODE_RD_ENT, 8'd0, 8'd0, 32'd0, 1'b0, 10'd0);
        write_reg(CFG_NUM_COLS, 9'd4);   // shrink before conversion
        send_word(MODE_LOAD, 8'd1, 8'd7, 32'h5, 1'b1, 10'd0);   // rejected, still converts
        send_word(MODE_RD_ENT, 8'd0, 8'd0, 32'd0, 1'b0, 10'd0);
        send_word(MODE_RD_ENT, 8'd0, 8'd0, 32'd0, 1'b0, 10'd1);
        send_word(MODE_RD_ENT, 8'd0, 8'd0, 32'd0, 1'b0, 10'd2);
        send_word(MODE_RD_ENT, 8'd0, 8'd0, 32'd0, 1'b0, 10'd3);
        send_word(MODE_RD_ENT, 8'd0, 8'd0, 32'd0, 1'b0, 10'h3ff);
        for (int c = 0; c <= 5; c++) send_word(MODE_RD_PTR, 8'd0, 8'd0, 32'd0, 1'b0, 10'(c));

        // settings: extremes first, then mixed
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin send_idle_pct = 56; recv_idle_pct = 16; end
            if (phase == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            items = 0;
            while (items < 230) begin
                case ($urandom_range(4))
                    0: begin write_reg(CFG_NUM_COLS, 9'd1); write_reg(CFG_NUM_ROWS, 9'd1); end
                    1: begin
                        write_reg(CFG_NUM_COLS, 9'd256);
                        write_reg(CFG_NUM_ROWS, 9'd256);
                    end
                    default: begin
                        write_reg(CFG_NUM_COLS, 9'($urandom_range(1, 511)));
                        write_reg(CFG_NUM_ROWS, 9'($urandom_range(1, 511)));
                    end
                endcase
                n_ld = $urandom_range(1, 30);
                n_rd = $urandom_range(10, 30);
                load_matrix(n_ld);
                read_back(n_rd);
                items += n_ld + n_rd;
            end
            // sink holds off while the source keeps offering
            if (phase == 0) begin
                fork
                    begin hold_sink = 1; repeat (300) @(posedge i_clk); hold_sink = 0; end
                    read_back(20);
                join
            end
        end

        drain();
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
